// ----- sv/nbsa_pkg.sv -----
package nbsa_pkg;

    localparam int BUCKETS_MAX     = 4;
    localparam int VARIANTS        = 2;
    localparam int POOL_MAX        = BUCKETS_MAX * VARIANTS;
    localparam int POOL_IDX_BITS   = $clog2(POOL_MAX);
    localparam int DEF_BUCKETS     = 4;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int CAP_BITS        = 16;
    localparam int CFG_IDX_BITS    = 4;
    localparam int BUCKET_BITS     = 2;
    localparam int OFFSET_COUNT    = 7;
    localparam int BUCKET_SUM_BITS = 4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // bucket search order around the requested bucket
    localparam logic signed [BUCKET_SUM_BITS-1:0] OFFSETS [OFFSET_COUNT] =
        '{4'sd0, -4'sd1, 4'sd1, -4'sd2, 4'sd2, -4'sd3, 4'sd3};

    typedef struct packed {
        logic                   func;
        logic [BUCKET_BITS-1:0] requested_bucket;
        logic                   preferred_variant;
    } t_request;

    typedef struct packed {
        logic                   granted;
        logic [BUCKET_BITS-1:0] granted_bucket;
        logic                   granted_variant;
        logic                   remapped;
    } t_result;

endpackage

// ----- sv/nbsa_req_if.sv -----
interface nbsa_req_if;
    import nbsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [BUCKET_BITS-1:0] requested_bucket;
    logic                   preferred_variant;

    modport source (output valid, func, requested_bucket, preferred_variant, input ready);
    modport sink   (input valid, func, requested_bucket, preferred_variant, output ready);
endinterface

// ----- sv/nbsa_res_if.sv -----
interface nbsa_res_if;
    import nbsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   granted;
    logic [BUCKET_BITS-1:0] granted_bucket;
    logic                   granted_variant;
    logic                   remapped;

    modport source (output valid, granted, granted_bucket, granted_variant, remapped,
                    input ready);
    modport sink   (input valid, granted, granted_bucket, granted_variant, remapped,
                    output ready);
endinterface

// ----- sv/nbsa_usage.sv -----
module nbsa_usage #(
    parameter int BUCKETS    = nbsa_pkg::DEF_BUCKETS,
    parameter int COUNT_BITS = nbsa_pkg::DEF_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [BUCKETS*nbsa_pkg::VARIANTS-1:0] i_inc,
    input  logic [nbsa_pkg::CAP_BITS-1:0] i_cap [nbsa_pkg::POOL_MAX],
    output logic [BUCKETS*nbsa_pkg::VARIANTS-1:0] o_free
);
    import nbsa_pkg::*;

    localparam int POOL_N   = BUCKETS * VARIANTS;
    localparam int CMP_BITS = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

    logic [COUNT_BITS-1:0] r_count [POOL_N];

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < POOL_N; e++) begin
            if (!i_rst_n || i_clear) begin
                r_count[e] <= '0;
            end else if (i_inc[e]) begin
                r_count[e] <= r_count[e] + COUNT_BITS'(1);
            end
        end
    end

    // saturated counters read as full
    always_comb begin
        for (int e = 0; e < POOL_N; e++) begin
            o_free[e] = (CMP_BITS'(r_count[e]) < CMP_BITS'(i_cap[e]))
                        && (r_count[e] != {COUNT_BITS{1'b1}});
        end
    end

    usage_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_clear && i_inc[0]) |=> (r_count[0] != '0))
        else $error("usage count wrapped");
endmodule

// ----- sv/nbsa_pick.sv -----
module nbsa_pick #(
    parameter int BUCKETS = nbsa_pkg::DEF_BUCKETS
) (
    input  nbsa_pkg::t_request                     i_req,
    input  logic [BUCKETS*nbsa_pkg::VARIANTS-1:0]  i_free,
    output nbsa_pkg::t_result                      o_grant,
    output logic [BUCKETS*nbsa_pkg::VARIANTS-1:0]  o_inc
);
    import nbsa_pkg::*;

    localparam int POOL_N = BUCKETS * VARIANTS;

    logic [POOL_MAX-1:0]                free_all;
    logic signed [BUCKET_SUM_BITS-1:0]  cand;
    logic                               var_sel;
    logic                               found;

    always_comb begin
        free_all = '0;
        free_all[POOL_N-1:0] = i_free;
    end

    always_comb begin
        found   = 1'b0;
        o_grant = '0;
        cand    = '0;
        var_sel = 1'b0;
        for (int k = 0; k < OFFSET_COUNT; k++) begin
            for (int p = 0; p < VARIANTS; p++) begin
                cand    = $signed({2'b00, i_req.requested_bucket}) + OFFSETS[k];
                var_sel = (p == 0) ? i_req.preferred_variant : ~i_req.preferred_variant;
                if (!found && cand >= 0
                        && cand < $signed(BUCKET_SUM_BITS'(BUCKETS))
                        && free_all[{cand[BUCKET_BITS-1:0], var_sel}]) begin
                    found                   = 1'b1;
                    o_grant.granted         = 1'b1;
                    o_grant.granted_bucket  = cand[BUCKET_BITS-1:0];
                    o_grant.granted_variant = var_sel;
                    o_grant.remapped        = cand[BUCKET_BITS-1:0] != i_req.requested_bucket;
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < POOL_N; e++) begin
            o_inc[e] = o_grant.granted
                       && ({o_grant.granted_bucket, o_grant.granted_variant}
                           == POOL_IDX_BITS'(e));
        end
    end
endmodule

// ----- sv/nearest_bucket_slot_allocator.sv -----
// pipeline: an accepted transaction is registered in r_in; its result is registered in r_out
//   once the output can advance, and the sink takes it from there
// throughput: one transaction per cycle unless the sink stalls; the usage update lands
//   before the next one is evaluated, so back-to-back requests see each other's grants
// reset: synchronous active low, clears both pipeline valids, all capacities
//   and all usage counts
module nearest_bucket_slot_allocator #(
    parameter int BUCKETS    = nbsa_pkg::DEF_BUCKETS,
    parameter int COUNT_BITS = nbsa_pkg::DEF_COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nbsa_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [nbsa_pkg::CAP_BITS-1:0]     i_cfg_data,
    nbsa_req_if.sink                          i_req,
    nbsa_res_if.source                        o_res
);
    import nbsa_pkg::*;

    localparam int POOL_N = BUCKETS * VARIANTS;

    logic [CAP_BITS-1:0] r_cap [POOL_MAX];
    logic                r_in_valid;
    logic                n_in_valid;
    t_request            r_in;
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                advance;
    logic                load_in;
    logic                do_step;
    logic [POOL_N-1:0]   free;
    logic [POOL_N-1:0]   pick_inc;
    logic [POOL_N-1:0]   inc;
    t_result             grant;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign load_in     = i_req.valid && i_req.ready;
    assign do_step     = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < POOL_MAX; e++) begin
                r_cap[e] <= '0;
            end
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_BITS'(POOL_MAX)) begin
            r_cap[i_cfg_idx[POOL_IDX_BITS-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (load_in) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = advance ? r_in_valid : r_out_valid;
        n_out       = (r_in.func == FUNC_CLEAR) ? '0 : grant;
        inc         = (do_step && r_in.func == FUNC_ALLOC) ? pick_inc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in.func              <= i_req.func;
            r_in.requested_bucket  <= i_req.requested_bucket;
            r_in.preferred_variant <= i_req.preferred_variant;
        end
        if (do_step) begin
            r_out <= n_out;
        end
    end

    nbsa_pick #(
        .BUCKETS (BUCKETS)
    ) u_pick (
        .i_req   (r_in),
        .i_free  (free),
        .o_grant (grant),
        .o_inc   (pick_inc)
    );

    nbsa_usage #(
        .BUCKETS    (BUCKETS),
        .COUNT_BITS (COUNT_BITS)
    ) u_usage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (do_step && r_in.func == FUNC_CLEAR),
        .i_inc   (inc),
        .i_cap   (r_cap),
        .o_free  (free)
    );

    assign o_res.valid           = r_out_valid;
    assign o_res.granted         = r_out.granted;
    assign o_res.granted_bucket  = r_out.granted_bucket;
    assign o_res.granted_variant = r_out.granted_variant;
    assign o_res.remapped        = r_out.remapped;

    grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.granted)
            |-> (r_out.granted_bucket <= BUCKET_BITS'(BUCKETS - 1)))
        else $error("grant outside the pool");

    miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.granted)
            |-> (!r_out.remapped && r_out.granted_bucket == '0 && !r_out.granted_variant))
        else $error("fields set without a grant");

    clear_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && r_in.func == FUNC_CLEAR) |=> (r_out_valid && !r_out.granted))
        else $error("clear transaction produced a grant");

    one_increment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(inc))
        else $error("more than one usage count incremented");

    stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held transaction lost during stall");
endmodule

// ----- tb/tb_nearest_bucket_slot_allocator.sv -----
`timescale 1ns / 1ps

module tb_nearest_bucket_slot_allocator;
    import nbsa_pkg::*;

    localparam int NBUCKETS     = DEF_BUCKETS;
    localparam int CNT_BITS     = DEF_COUNT_BITS;
    localparam int PHASE_ITEMS  = 190;
    localparam int FILL_ITEMS   = 60;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;
    localparam int SEARCH_ORDER [OFFSET_COUNT] = '{0, -1, 1, -2, 2, -3, 3};

    typedef enum int {CAPS_EMPTY, CAPS_FULL, CAPS_RANDOM} t_cap_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [CAP_BITS-1:0] cfg_data;

    nbsa_req_if req_ch ();
    nbsa_res_if res_ch ();

    nearest_bucket_slot_allocator #(
        .BUCKETS    (NBUCKETS),
        .COUNT_BITS (CNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // predictor state
    logic [CAP_BITS-1:0] capacity [POOL_MAX];
    logic [CNT_BITS-1:0] usage [POOL_MAX];

    // both queues are filled at the front and emptied from the back
    t_request req_backlog [$];
    t_result  grants_due [$];
    int       mismatches = 0;

    int burst_left;
    int gap_left;
    logic [15:0] ready_pat;
    logic [3:0]  pat_pos;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void queue_req(t_request rq);
        req_backlog.push_front(rq);
    endfunction

    function automatic void queue_grant(t_result rs);
        grants_due.push_front(rs);
    endfunction

    function automatic t_result grant_slot(t_request rq);
        t_result r;
        int b;
        int v;
        int slot;
        r = '0;
        if (rq.func == FUNC_CLEAR) begin
            foreach (usage[k]) usage[k] = '0;
            return r;
        end
        for (int k = 0; k < OFFSET_COUNT; k++) begin
            b = int'(rq.requested_bucket) + SEARCH_ORDER[k];
            if (b < 0 || b >= NBUCKETS) continue;
            for (int p = 0; p < VARIANTS; p++) begin
                v = (p == 0) ? int'(rq.preferred_variant) : 1 - int'(rq.preferred_variant);
                slot = b * VARIANTS + v;
                if (usage[slot] < capacity[slot] && usage[slot] < COUNT_MAX) begin
                    usage[slot] = usage[slot] + 1'b1;
                    r.granted         = 1'b1;
                    r.granted_bucket  = BUCKET_BITS'(b);
                    r.granted_variant = v[0];
                    r.remapped        = (b != int'(rq.requested_bucket));
                    return r;
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string field, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function automatic t_request make_req(logic fn, int bucket, int variant);
        t_request rq;
        rq.func              = fn;
        rq.requested_bucket  = BUCKET_BITS'(bucket);
        rq.preferred_variant = variant[0];
        return rq;
    endfunction

    function automatic t_request rand_req(int clear_odds);
        return make_req(($urandom_range(0, clear_odds - 1) == 0) ? FUNC_CLEAR : FUNC_ALLOC,
                        $urandom_range(0, 3), $urandom_range(0, 1));
    endfunction

    task automatic write_cap(input int idx, input logic [CAP_BITS-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_BITS'(idx);
        cfg_data <= val;
        if (idx < POOL_MAX) capacity[idx] = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_capacities(input t_cap_mode mode);
        logic [CAP_BITS-1:0] val;
        for (int k = 0; k < POOL_MAX; k++) begin
            case (mode)
                CAPS_EMPTY: val = '0;
                CAPS_FULL:  val = '1;
                default: begin
                    if ($urandom_range(0, 7) == 0) val = CAP_BITS'($urandom);
                    else val = CAP_BITS'($urandom_range(0, 4));
                end
            endcase
            write_cap(k, val);
        end
        // unused register space, must be ignored
        write_cap($urandom_range(POOL_MAX, (1 << CFG_IDX_BITS) - 1), CAP_BITS'($urandom));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || req_ch.valid || grants_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // driver: bursts of transactions with random gaps
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                nxt = req_backlog.pop_back();
                req_ch.valid             <= 1'b1;
                req_ch.func              <= nxt.func;
                req_ch.requested_bucket  <= nxt.requested_bucket;
                req_ch.preferred_variant <= nxt.preferred_variant;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall windows from a random 16-bit ready pattern, first cycle of each always ready
    always @(posedge i_clk) begin
        logic [15:0] pat;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_pat    <= '1;
            pat_pos      <= '0;
        end else begin
            res_ch.ready <= ready_pat[pat_pos];
            pat_pos      <= pat_pos + 1'b1;
            if (pat_pos == 4'hf) begin
                case ($urandom_range(0, 3))
                    0:       pat = '1;
                    1:       pat = 16'($urandom);
                    2:       pat = 16'($urandom | $urandom);
                    default: pat = 16'($urandom & $urandom);
                endcase
                pat[0] = 1'b1;
                ready_pat <= pat;
            end
        end
    end

    // monitor: check results, then predict for newly accepted requests
    always @(posedge i_clk) begin
        t_result  want;
        t_request seen;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (grants_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, got %0b %0d %0b %0b", $time,
                             res_ch.granted, res_ch.granted_bucket,
                             res_ch.granted_variant, res_ch.remapped);
                end else begin
                    want = grants_due.pop_back();
                    check_field("granted", want.granted, res_ch.granted);
                    check_field("granted_bucket", want.granted_bucket, res_ch.granted_bucket);
                    check_field("granted_variant", want.granted_variant,
                                res_ch.granted_variant);
                    check_field("remapped", want.remapped, res_ch.remapped);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.func              = req_ch.func;
                seen.requested_bucket  = req_ch.requested_bucket;
                seen.preferred_variant = req_ch.preferred_variant;
                queue_grant(grant_slot(seen));
            end
        end
    end

    initial begin
        #(100_000_000);
        $display("tb_nearest_bucket_slot_allocator failed");
        $finish;
    end

    initial begin
        int clear_odds;
        foreach (capacity[k]) capacity[k] = '0;
        foreach (usage[k]) usage[k] = '0;
        i_rst_n                  = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = '0;
        cfg_data                 = '0;
        req_ch.valid             = 1'b0;
        req_ch.func              = FUNC_ALLOC;
        req_ch.requested_bucket  = '0;
        req_ch.preferred_variant = 1'b0;
        res_ch.ready             = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // capacities still at reset: nothing can be granted
        @(negedge i_clk);
        queue_req(make_req(FUNC_ALLOC, 0, 0));
        queue_req(make_req(FUNC_ALLOC, 3, 1));
        wait_idle();

        write_cap(0, 16'd1);
        write_cap(1, 16'd0);
        write_cap(2, 16'd0);
        write_cap(3, 16'd1);
        write_cap(4, 16'd2);
        write_cap(5, 16'd0);
        write_cap(6, 16'd0);
        write_cap(7, 16'd1);
        write_cap(POOL_MAX, '1);
        @(negedge i_clk);
        // own slot, remap down and up, exhaustion, clear and refill
        queue_req(make_req(FUNC_ALLOC, 0, 0));
        queue_req(make_req(FUNC_ALLOC, 0, 0));
        queue_req(make_req(FUNC_ALLOC, 3, 1));
        queue_req(make_req(FUNC_ALLOC, 3, 0));
        queue_req(make_req(FUNC_ALLOC, 1, 1));
        queue_req(make_req(FUNC_ALLOC, 2, 0));
        queue_req(make_req(FUNC_ALLOC, 0, 1));
        queue_req(make_req(FUNC_CLEAR, 3, 1));
        queue_req(make_req(FUNC_ALLOC, 2, 1));
        queue_req(make_req(FUNC_ALLOC, 3, 1));
        queue_req(make_req(FUNC_ALLOC, 0, 1));
        queue_req(make_req(FUNC_ALLOC, 1, 0));
        queue_req(make_req(FUNC_ALLOC, 2, 1));
        queue_req(make_req(FUNC_ALLOC, 1, 0));
        queue_req(make_req(FUNC_CLEAR, 0, 0));
        queue_req(make_req(FUNC_ALLOC, 3, 0));
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) load_capacities(CAPS_EMPTY);
            else if (ph == 1) load_capacities(CAPS_FULL);
            else load_capacities(CAPS_RANDOM);
            clear_odds = $urandom_range(6, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) queue_req(rand_req(clear_odds));
            wait_idle();
        end

        // one entry with a large capacity, a single slot beside it, nothing elsewhere
        for (int k = 0; k < POOL_MAX; k++)
            write_cap(k, (k == 0) ? '1 : ((k == 1) ? 16'd1 : 16'd0));
        @(negedge i_clk);
        queue_req(make_req(FUNC_CLEAR, 0, 0));
        for (int n = 0; n < FILL_ITEMS; n++)
            queue_req(make_req(FUNC_ALLOC, $urandom_range(0, 3), $urandom_range(0, 1)));
        wait_idle();

        if (mismatches == 0) begin
            $display("tb_nearest_bucket_slot_allocator passed");
        end else begin
            $display("tb_nearest_bucket_slot_allocator failed");
        end
        $finish;
    end

endmodule
